>>> design/sbg_pkg.sv
`default_nettype none
package sbg_pkg;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam int unsigned DISP_COLS   = 128;
  localparam int unsigned BAR_SPAN    = 55;
  localparam int unsigned SAMPLE_FULL = 4095;
  localparam int unsigned LAST_ROW    = 63;
  localparam int unsigned SEP_PAGE    = 1;
  localparam int unsigned HDR_PAGE    = 0;

  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_LW    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic        kind;
    logic        vis;
    logic [11:0] sample;
    logic [2:0]  page;
  } sbg_op_t;

  localparam int unsigned OP_W = $bits(sbg_op_t);

endpackage
`default_nettype wire

>>> design/sbg_fifo.sv
`default_nettype none
module sbg_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr,
  input  logic [WIDTH-1:0]                 din,
  output logic                             full,
  input  logic                             rd,
  output logic [WIDTH-1:0]                 dout,
  output logic                             empty,
  output logic [$clog2(DEPTH+1)-1:0]       level
);
  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned LW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign full  = (cnt_r == LW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign level = cnt_r;
  assign dout  = mem_r[rp_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_rd) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule
`default_nettype wire

>>> design/sbg_front.sv
`default_nettype none
module sbg_front #(
  parameter int unsigned NUM_SAMPLES = 128
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          push,
  input  logic                                          in_kind,
  input  logic [11:0]                                   in_sample,
  input  logic [6:0]                                    in_column,
  input  logic [2:0]                                    in_page,
  input  logic                                          q_full,
  output logic                                          q_wr,
  output logic [$clog2(NUM_SAMPLES)+sbg_pkg::OP_W-1:0] q_din
);
  import sbg_pkg::*;

  localparam int unsigned HW = $clog2(NUM_SAMPLES);
  localparam int unsigned FW = $clog2(NUM_SAMPLES + 1);
  localparam int unsigned AW = ((HW > 7) ? HW : 7) + 2;

  logic [HW-1:0] head_r, head_nxt, newest, idx;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [6:0]    age;
  logic [AW-1:0] diff, wrapped;
  logic          vis;
  sbg_op_t       op;

  assign q_wr = push && !q_full;
  assign age  = 7'(DISP_COLS - 1) - in_column;

  always_comb begin
    newest  = (head_r == '0) ? HW'(NUM_SAMPLES - 1) : head_r - 1'b1;
    diff    = AW'(newest) - AW'(age);
    wrapped = diff[AW-1] ? diff + AW'(NUM_SAMPLES) : diff;
    vis     = AW'(age) < AW'(fill_r);
    idx     = (in_kind == KIND_PUSH) ? head_r : wrapped[HW-1:0];
    op.kind   = in_kind;
    op.vis    = vis;
    op.sample = in_sample;
    op.page   = in_page;
    q_din     = {idx, op};
  end

  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (q_wr && in_kind == KIND_PUSH) begin
      head_nxt = (head_r == HW'(NUM_SAMPLES - 1)) ? '0 : head_r + 1'b1;
      if (fill_r != FW'(NUM_SAMPLES)) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

>>> design/sbg_back.sv
`default_nettype none
module sbg_back #(
  parameter int unsigned NUM_SAMPLES = 128
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic [$clog2(NUM_SAMPLES)+sbg_pkg::OP_W-1:0] q_dout,
  input  logic                                          q_empty,
  output logic                                          q_rd,
  input  logic [sbg_pkg::OUT_LW-1:0]                    o_level,
  output logic                                          o_wr,
  output logic [7:0]                                    o_din
);
  import sbg_pkg::*;

  localparam int unsigned HW = $clog2(NUM_SAMPLES);

  logic [11:0]   hist_r [NUM_SAMPLES];
  logic [11:0]   rd_data_r;
  logic          s1_valid_r, s1_kind_r, s1_vis_r;
  logic [2:0]    s1_page_r;
  sbg_op_t       op;
  logic [HW-1:0] idx;
  logic [OUT_LW:0] pending;
  logic          issue;
  logic [17:0]   prod;
  logic [5:0]    q0, h;
  logic [12:0]   rem;
  logic [6:0]    top;
  logic [7:0]    bar;

  assign op      = sbg_op_t'(q_dout[OP_W-1:0]);
  assign idx     = q_dout[HW+OP_W-1:OP_W];
  assign pending = (OUT_LW + 1)'(o_level) + (OUT_LW + 1)'(s1_valid_r);
  assign issue   = !q_empty && (pending < (OUT_LW + 1)'(OUT_DEPTH));
  assign q_rd    = issue;

  always_ff @(posedge clk) begin
    if (issue) begin
      if (op.kind == KIND_PUSH) begin
        hist_r[idx] <= op.sample;
      end else begin
        rd_data_r <= hist_r[idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_kind_r <= op.kind;
      s1_vis_r  <= op.vis;
      s1_page_r <= op.page;
    end
  end

  always_comb begin
    prod = rd_data_r * 18'(BAR_SPAN);
    q0   = prod[17:12];
    rem  = {1'b0, prod[11:0]} + 13'(q0);
    h    = (rem >= 13'(SAMPLE_FULL)) ? q0 + 1'b1 : q0;
    if (h == '0) begin
      h = 6'd1;
    end
    top = 7'(LAST_ROW + 1) - 7'(h);
    for (int k = 0; k < 8; k++) begin
      bar[k] = s1_vis_r && ({1'b0, s1_page_r, 3'(k)} >= top);
    end
    o_din = '0;
    if (s1_kind_r == KIND_READ && s1_page_r != 3'(HDR_PAGE)) begin
      o_din = bar;
      if (s1_page_r == 3'(SEP_PAGE)) begin
        o_din[0] = 1'b1;
      end
    end
  end

  assign o_wr = s1_valid_r;

endmodule
`default_nettype wire

>>> design/scrolling_bar_graph_renderer_unit.sv
// Scrolling strip-chart bar graph renderer.
// The input channel is a queue port: an item is taken at a clock edge with
// push high and full low. A push item (in_kind 0) appends in_sample to the
// sample ring; a read item (in_kind 1) asks for the display byte at
// in_column and in_page of a 128x64 bar graph, newest sample on the right.
// Every item yields exactly one result, zero for a push item.
// The result channel is a queue port: while empty is low the oldest result
// sits on out_page_bits, and it is taken at an edge with pop high.
// One item per cycle is sustained while the receiver keeps popping:
// the front classifies an item in the cycle it arrives, the back does
// one sample memory access per cycle and computes the byte in the
// following cycle.
// Synchronous reset empties both queues and clears the write head and the
// fill count; the sample memory is not cleared. When the receiver stops
// popping, the four-entry result queue fills, the back stops issuing, the
// four-entry item queue fills and full is raised; nothing is dropped.
`default_nettype none
module scrolling_bar_graph_renderer_unit #(
  parameter int unsigned NUM_SAMPLES = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_kind,
  input  logic [11:0] in_sample,
  input  logic [6:0]  in_column,
  input  logic [2:0]  in_page,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_page_bits
);
  import sbg_pkg::*;

  localparam int unsigned QW = $clog2(NUM_SAMPLES) + OP_W;

  logic              q_wr, q_rd, q_full, q_empty;
  logic [QW-1:0]     q_din, q_dout;
  logic [$clog2(MID_DEPTH+1)-1:0] q_level;
  logic              o_wr, o_full;
  logic [7:0]        o_din;
  logic [OUT_LW-1:0] o_level;

  assign full = q_full;

  sbg_front #(.NUM_SAMPLES(NUM_SAMPLES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_kind   (in_kind),
    .in_sample (in_sample),
    .in_column (in_column),
    .in_page   (in_page),
    .q_full    (q_full),
    .q_wr      (q_wr),
    .q_din     (q_din)
  );

  sbg_fifo #(.WIDTH(QW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .din   (q_din),
    .full  (q_full),
    .rd    (q_rd),
    .dout  (q_dout),
    .empty (q_empty),
    .level (q_level)
  );

  sbg_back #(.NUM_SAMPLES(NUM_SAMPLES)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_dout  (q_dout),
    .q_empty (q_empty || (q_level == '0)),
    .q_rd    (q_rd),
    .o_level (o_level),
    .o_wr    (o_wr),
    .o_din   (o_din)
  );

  sbg_fifo #(.WIDTH(8), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (o_wr),
    .din   (o_din),
    .full  (o_full),
    .rd    (pop),
    .dout  (out_page_bits),
    .empty (empty),
    .level (o_level)
  );

endmodule
`default_nettype wire

>>> design/sbg_checker.sv
`default_nettype none
module sbg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_page_bits
);
  logic [7:0] outstanding_r, outstanding_nxt;

  always_comb begin
    outstanding_nxt = outstanding_r + 8'(push && !full) - 8'(pop && !empty);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else begin
      outstanding_r <= outstanding_nxt;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not idle after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_page_bits))
    else $error("waiting result changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> outstanding_r != 8'd0)
    else $error("result shown with no item outstanding");

  a_bar_shape: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_page_bits[6:1] & ~out_page_bits[7:2]) == 6'd0))
    else $error("bar pixels not contiguous down to the bottom row");

endmodule

bind scrolling_bar_graph_renderer_unit sbg_checker u_sbg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .pop           (pop),
  .empty         (empty),
  .out_page_bits (out_page_bits)
);
`default_nettype wire
